FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MLCD_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed: lbl");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MLCD_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed: lbl");

`endif

FILE: rtl/core/mlcd_pkg.sv
// Shared constants, codes and types of the memory LCD frame controller.
`default_nettype none
package mlcd_pkg;

    localparam int PANEL_WIDTH  = 144;
    localparam int PANEL_HEIGHT = 168;
    localparam int LINE_BYTES   = (PANEL_WIDTH + 7) / 8;
    localparam int STORE_DEPTH  = PANEL_HEIGHT * LINE_BYTES;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int COL_W        = $clog2(PANEL_WIDTH) + 1;

    localparam logic [7:0] FILL_BYTE = 8'hFF;

    typedef logic [2:0] req_t;
    localparam req_t REQ_DRAW    = 3'd0;
    localparam req_t REQ_READ    = 3'd1;
    localparam req_t REQ_WRITE   = 3'd2;
    localparam req_t REQ_CLEAR   = 3'd3;
    localparam req_t REQ_REFRESH = 3'd4;
    localparam req_t REQ_SLOT    = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;

    localparam logic [2:0] CFG_ROTATION  = 3'd0;
    localparam logic [2:0] CFG_WRITE_CMD = 3'd1;
    localparam logic [2:0] CFG_CLEAR_CMD = 3'd2;
    localparam logic [2:0] CFG_VCOM_MASK = 3'd3;
    localparam logic [2:0] CFG_NOP_BYTE  = 3'd4;
    localparam logic [2:0] CFG_BIT_ORDER = 3'd5;

    typedef struct packed {
        req_t              req;
        logic              oor;
        logic              ink;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bitk;
        logic [7:0]        line;
        logic [7:0]        value;
    } item_t;

    typedef struct packed {
        logic [1:0] rotation;
        logic [7:0] write_command;
        logic [7:0] clear_command;
        logic [7:0] vcom_mask;
        logic [7:0] nop_byte;
        logic       pixel_bit_order;
    } cfg_t;

    typedef struct packed {
        logic [1:0] status;
        logic       pixel_value;
        logic       serial_valid;
        logic [7:0] serial_byte;
        logic       frame_first;
        logic       frame_last;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/mlcd_front.sv
// Front end: decodes each word, maps coordinates to a store address, queues it.
`default_nettype none
module mlcd_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [47:0]    s_tdata,   // pixel_x, pixel_y, ink, line_index, byte_index, byte_value
    input  wire logic [2:0]     s_tuser,   // req_type
    input  wire mlcd_pkg::cfg_t cfg,
    input  wire logic           clearing,
    output logic                q_valid,
    input  wire logic           q_pop,
    output mlcd_pkg::item_t     q_item
);
    import mlcd_pkg::*;

    localparam logic signed [12:0] PW_M1 = 13'(PANEL_WIDTH - 1);
    localparam logic signed [12:0] PH_M1 = 13'(PANEL_HEIGHT - 1);

    logic signed [12:0] vx, vy, vw, vh, px, py;
    logic               in_view;
    logic [7:0]         line8;
    logic [COL_W-1:0]   col;
    logic [ADDR_W-1:0]  pix_addr, byte_addr;
    logic [7:0]         li;
    logic [5:0]         bi;
    logic               wr_ok;
    item_t              item;

    item_t      ent_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       push;

    always_comb
    begin
        vx = {s_tdata[11], s_tdata[11:0]};
        vy = {s_tdata[23], s_tdata[23:12]};
        vw = cfg.rotation[0] ? 13'(PANEL_HEIGHT) : 13'(PANEL_WIDTH);
        vh = cfg.rotation[0] ? 13'(PANEL_WIDTH) : 13'(PANEL_HEIGHT);
        in_view = !vx[12] && !vy[12] && (vx < vw) && (vy < vh);
        case (cfg.rotation)
            2'd1:
            begin
                px = PW_M1 - vy;
                py = vx;
            end
            2'd2:
            begin
                px = PW_M1 - vx;
                py = PH_M1 - vy;
            end
            2'd3:
            begin
                px = vy;
                py = PH_M1 - vx;
            end
            default:
            begin
                px = vx;
                py = vy;
            end
        endcase
        line8    = py[7:0];
        col      = px[COL_W-1:0];
        pix_addr = ADDR_W'(line8) * ADDR_W'(LINE_BYTES) + ADDR_W'(col[COL_W-1:3]);

        li        = s_tdata[32:25];
        bi        = s_tdata[38:33];
        wr_ok     = (9'(li) < 9'(PANEL_HEIGHT)) && (7'(bi) < 7'(LINE_BYTES));
        byte_addr = ADDR_W'(li) * ADDR_W'(LINE_BYTES) + ADDR_W'(bi);

        item.req   = s_tuser;
        item.ink   = s_tdata[24];
        item.value = s_tdata[46:39];
        item.bitk  = col[2:0];
        if (s_tuser == REQ_WRITE)
        begin
            item.oor  = !wr_ok;
            item.addr = byte_addr;
            item.line = li;
        end
        else
        begin
            item.oor  = !in_view;
            item.addr = pix_addr;
            item.line = line8;
        end
    end

    assign s_tready = (cnt_reg != 2'd2) && !clearing;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_item   = ent_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (q_pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_reg] <= item;
    end

endmodule
`default_nettype wire

FILE: rtl/core/mlcd_back.sv
// Back end: frame store, dirty marks, transfer sequencer and result register.
`default_nettype none
module mlcd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mlcd_pkg::cfg_t  cfg,
    input  wire logic            q_valid,
    input  wire mlcd_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 clearing,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output mlcd_pkg::result_t    m_res
);
    import mlcd_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_DEPTH - 1);

    typedef enum logic [1:0] {S_CLR, S_IDLE, S_MOD, S_SEEK} state_t;
    typedef enum logic [2:0] {
        PH_IDLE, PH_CLEAR_CMD, PH_VCOM_CMD, PH_WRITE_CMD,
        PH_LINE_NUM, PH_LINE_DATA, PH_LINE_NOP, PH_TRAILER
    } phase_t;

    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
            r[7-i] = v[i];
        return r;
    endfunction

    state_t                  state_reg;
    phase_t                  phase_reg;
    item_t                   item_reg;
    logic [PANEL_HEIGHT-1:0] dirty_reg;
    logic                    any_reg, vcom_reg, out_valid_reg;
    logic [7:0]              tline_reg, scan_reg;
    logic [5:0]              tbyte_reg;
    logic [ADDR_W-1:0]       taddr_reg, clr_reg;
    result_t                 res_reg;

    logic [7:0]        mem [STORE_DEPTH];
    logic [7:0]        rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;

    logic       take, busy, emit;
    logic [7:0] vbits, mask;
    result_t    res_next;

    assign take     = (state_reg == S_IDLE) && q_valid && (!out_valid_reg || m_tready);
    assign q_pop    = take;
    assign busy     = phase_reg != PH_IDLE;
    assign vbits    = vcom_reg ? cfg.vcom_mask : 8'h00;
    assign mask     = cfg.pixel_bit_order ? (8'h80 >> item_reg.bitk) : (8'h01 << item_reg.bitk);
    assign clearing = state_reg == S_CLR;
    assign m_tvalid = out_valid_reg;
    assign m_res    = res_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = q_item.addr;
        mem_wdata = FILL_BYTE;
        case (state_reg)
            S_CLR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
            end
            S_IDLE:
            begin
                if (phase_reg == PH_LINE_DATA && q_item.req == REQ_SLOT)
                    mem_addr = taddr_reg;
                if (take && q_item.req == REQ_WRITE && !q_item.oor && !busy)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = q_item.value;
                end
            end
            S_MOD:
            begin
                mem_addr  = item_reg.addr;
                mem_we    = item_reg.req == REQ_DRAW;
                mem_wdata = item_reg.ink ? (rdata_reg | mask) : (rdata_reg & ~mask);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rdata_reg <= mem[mem_addr];
    end

    always_comb
    begin
        emit     = 1'b0;
        res_next = '0;
        if (take)
        begin
            case (q_item.req)
                REQ_DRAW, REQ_READ:
                begin
                    if (busy && q_item.req == REQ_DRAW)
                    begin
                        emit            = 1'b1;
                        res_next.status = ST_BUSY;
                    end
                    else if (q_item.oor)
                    begin
                        emit            = 1'b1;
                        res_next.status = ST_RANGE;
                    end
                end
                REQ_WRITE:
                begin
                    emit = 1'b1;
                    if (busy)
                        res_next.status = ST_BUSY;
                    else if (q_item.oor)
                        res_next.status = ST_RANGE;
                end
                REQ_CLEAR, REQ_REFRESH:
                begin
                    emit = 1'b1;
                    if (busy)
                        res_next.status = ST_BUSY;
                end
                REQ_SLOT:
                begin
                    emit = phase_reg != PH_LINE_DATA;
                    res_next.serial_valid = busy;
                    case (phase_reg)
                        PH_CLEAR_CMD:
                        begin
                            res_next.serial_byte = cfg.clear_command | vbits;
                            res_next.frame_first = 1'b1;
                        end
                        PH_VCOM_CMD:
                        begin
                            res_next.serial_byte = vbits;
                            res_next.frame_first = 1'b1;
                        end
                        PH_WRITE_CMD:
                        begin
                            res_next.serial_byte = cfg.write_command | vbits;
                            res_next.frame_first = 1'b1;
                        end
                        PH_LINE_NUM: res_next.serial_byte = flip8(tline_reg + 8'd1);
                        PH_LINE_NOP: res_next.serial_byte = cfg.nop_byte;
                        PH_TRAILER:
                        begin
                            res_next.serial_byte = cfg.nop_byte;
                            res_next.frame_last  = 1'b1;
                        end
                        default: ;
                    endcase
                end
                default:
                begin
                    emit            = 1'b1;
                    res_next.status = ST_RANGE;
                end
            endcase
        end
        else if (state_reg == S_MOD)
        begin
            emit = 1'b1;
            case (item_reg.req)
                REQ_DRAW: ;
                REQ_READ: res_next.pixel_value = |(rdata_reg & mask);
                default:
                begin
                    res_next.serial_valid = 1'b1;
                    res_next.serial_byte  = flip8(rdata_reg);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            phase_reg     <= PH_IDLE;
            item_reg      <= '0;
            dirty_reg     <= '0;
            any_reg       <= 1'b0;
            vcom_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            tline_reg     <= 8'd0;
            scan_reg      <= 8'd0;
            tbyte_reg     <= 6'd0;
            taddr_reg     <= '0;
            clr_reg       <= '0;
            res_reg       <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                res_reg       <= res_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + ADDR_W'(1);
                    if (clr_reg == ADDR_LAST)
                    begin
                        clr_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (take)
                    begin
                        item_reg <= q_item;
                        case (q_item.req)
                            REQ_DRAW, REQ_READ:
                                if ((!busy || q_item.req == REQ_READ) && !q_item.oor)
                                    state_reg <= S_MOD;
                            REQ_WRITE:
                                if (!busy && !q_item.oor)
                                begin
                                    dirty_reg[q_item.line] <= 1'b1;
                                    any_reg                <= 1'b1;
                                end
                            REQ_CLEAR:
                                if (!busy)
                                begin
                                    state_reg <= S_CLR;
                                    dirty_reg <= '0;
                                    any_reg   <= 1'b0;
                                    phase_reg <= PH_CLEAR_CMD;
                                end
                            REQ_REFRESH:
                                if (!busy)
                                begin
                                    phase_reg <= any_reg ? PH_WRITE_CMD : PH_VCOM_CMD;
                                    any_reg   <= 1'b0;
                                end
                            REQ_SLOT:
                                case (phase_reg)
                                    PH_CLEAR_CMD, PH_VCOM_CMD: phase_reg <= PH_TRAILER;
                                    PH_WRITE_CMD:
                                    begin
                                        scan_reg  <= 8'd0;
                                        state_reg <= S_SEEK;
                                    end
                                    PH_LINE_NUM:
                                    begin
                                        tbyte_reg <= 6'd0;
                                        phase_reg <= PH_LINE_DATA;
                                    end
                                    PH_LINE_DATA: state_reg <= S_MOD;
                                    PH_LINE_NOP:
                                    begin
                                        dirty_reg[tline_reg] <= 1'b0;
                                        scan_reg             <= tline_reg + 8'd1;
                                        state_reg            <= S_SEEK;
                                    end
                                    PH_TRAILER:
                                    begin
                                        vcom_reg  <= !vcom_reg;
                                        phase_reg <= PH_IDLE;
                                    end
                                    default: ;
                                endcase
                            default: ;
                        endcase
                    end
                end
                S_MOD:
                begin
                    state_reg <= S_IDLE;
                    if (item_reg.req == REQ_DRAW)
                    begin
                        dirty_reg[item_reg.line] <= 1'b1;
                        any_reg                  <= 1'b1;
                    end
                    else if (item_reg.req == REQ_SLOT)
                    begin
                        tbyte_reg <= tbyte_reg + 6'd1;
                        taddr_reg <= taddr_reg + ADDR_W'(1);
                        if (7'(tbyte_reg) + 7'd1 >= 7'(LINE_BYTES))
                            phase_reg <= PH_LINE_NOP;
                    end
                end
                S_SEEK:
                begin
                    if (9'(scan_reg) >= 9'(PANEL_HEIGHT))
                    begin
                        phase_reg <= PH_TRAILER;
                        state_reg <= S_IDLE;
                    end
                    else if (dirty_reg[scan_reg])
                    begin
                        tline_reg <= scan_reg;
                        tbyte_reg <= 6'd0;
                        taddr_reg <= ADDR_W'(scan_reg) * ADDR_W'(LINE_BYTES);
                        phase_reg <= PH_LINE_NUM;
                        state_reg <= S_IDLE;
                    end
                    else
                        scan_reg <= scan_reg + 8'd1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/memory_lcd_frame_controller.sv
// Top level of the memory LCD frame controller: config registers and wiring.
// Usage:
//   s_* carries one request word (req_type in s_tuser). m_* returns exactly one
//   result word per request, in order. cfg_* writes a register (index, data);
//   cfg_ready is always high, writes take effect on the next cycle.
// Sequencing:
//   a request enters a two-word queue, then the sequencer works on one at a
//   time. Most requests get their result registered in the cycle after they
//   leave the queue; pixel draw, pixel read and a line data byte first pass
//   through S_MOD (registered store read); a byte slot that ends a line or the
//   command byte searches the dirty marks one line a cycle, up to PANEL_HEIGHT
//   lines. A clear sweeps the STORE_DEPTH (3024) store bytes, one byte a cycle, with s_tready low.
// Reset:
//   rst_n low clears control state; afterwards the store is filled with 0xFF
//   in one pass over the store during which s_tready stays low.
// Stall:
//   the result register holds while m_tready is low; the queue keeps taking
//   words until it is full, then s_tready drops.
`default_nettype none
`include "assert_macros.svh"
module memory_lcd_frame_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // pixel_x, pixel_y, ink, line_index, byte_index, byte_value
    input  wire logic [2:0]  s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // status, pixel_value, serial_valid, serial_byte
    output logic             m_tuser,   // frame_first
    output logic             m_tlast,   // frame_last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import mlcd_pkg::*;

    cfg_t    cfg_reg;
    logic    q_valid, q_pop, clearing;
    item_t   q_item;
    result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotation        <= 2'd0;
            cfg_reg.write_command   <= 8'h80;
            cfg_reg.clear_command   <= 8'h20;
            cfg_reg.vcom_mask       <= 8'h40;
            cfg_reg.nop_byte        <= 8'h00;
            cfg_reg.pixel_bit_order <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROTATION:  cfg_reg.rotation        <= cfg_data[1:0];
                CFG_WRITE_CMD: cfg_reg.write_command   <= cfg_data;
                CFG_CLEAR_CMD: cfg_reg.clear_command   <= cfg_data;
                CFG_VCOM_MASK: cfg_reg.vcom_mask       <= cfg_data;
                CFG_NOP_BYTE:  cfg_reg.nop_byte        <= cfg_data;
                CFG_BIT_ORDER: cfg_reg.pixel_bit_order <= cfg_data[0];
                default: ;
            endcase
        end
    end

    mlcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    mlcd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (res)
    );

    assign m_tdata = {4'b0000, res.serial_byte, res.serial_valid, res.pixel_value, res.status};
    assign m_tuser = res.frame_first;
    assign m_tlast = res.frame_last;

    `MLCD_ASSERT_IMP(a_first_has_byte, m_tvalid && res.frame_first, res.serial_valid)
    `MLCD_ASSERT_IMP(a_last_alone, m_tvalid && res.frame_last, res.serial_valid && !res.frame_first)
    `MLCD_ASSERT_IMP(a_error_quiet, m_tvalid && res.status != ST_DONE, !res.serial_valid && !res.pixel_value)
    `MLCD_ASSERT_IMP(a_clear_no_take, clearing, !q_pop)

endmodule
`default_nettype wire
